FILE: hdl/ehff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ethernet header frame filter package
// Shared constants, codes and record types for the frame filter.
// ----------------------------------------------------------------------------
package ehff_pkg;

  localparam int unsigned HDR_LEN  = 34;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned MAC_W    = 48;
  localparam int unsigned IP_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 48;

  // byte offsets in the frame
  localparam logic [POS_W-1:0] POS_SMAC  = 6'd6;
  localparam logic [POS_W-1:0] POS_ETYPE = 6'd12;
  localparam logic [POS_W-1:0] POS_L2END = 6'd14;
  localparam logic [POS_W-1:0] POS_PROTO = 6'd23;
  localparam logic [POS_W-1:0] POS_SIP   = 6'd26;
  localparam logic [POS_W-1:0] POS_DIP   = 6'd30;
  localparam logic [POS_W-1:0] POS_END   = 6'd34;

  // minimum frame lengths for each check
  localparam logic [POS_W-1:0] LEN_DMAC  = 6'd6;
  localparam logic [POS_W-1:0] LEN_SMAC  = 6'd12;
  localparam logic [POS_W-1:0] LEN_L2    = 6'd14;
  localparam logic [POS_W-1:0] LEN_PROTO = 6'd24;
  localparam logic [POS_W-1:0] LEN_SIP   = 6'd30;
  localparam logic [POS_W-1:0] LEN_DIP   = 6'd34;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  // filter_kind codes
  localparam logic [1:0] KIND_IP    = 2'd0;
  localparam logic [1:0] KIND_MAC   = 2'd1;
  localparam logic [1:0] KIND_PROTO = 2'd2;

  // filter_type codes
  localparam logic [2:0] SEL_SOURCE = 3'd0;
  localparam logic [2:0] TYPE_ARP   = 3'd1;
  localparam logic [2:0] TYPE_ICMP  = 3'd2;
  localparam logic [2:0] TYPE_TCP   = 3'd3;
  localparam logic [2:0] TYPE_UDP   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAC  = 2'd3;

  typedef struct packed {
    logic [1:0]      kind;
    logic [2:0]      ftype;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } cfg_t;

  // per-frame summary handed from the parser to the verdict stage
  typedef struct packed {
    logic [POS_W-1:0] len;
    logic ipv4;
    logic arp;
    logic icmp;
    logic tcp;
    logic udp;
    logic sip_eq;
    logic dip_eq;
    logic smac_eq;
    logic dmac_eq;
  } rec_t;

endpackage

FILE: hdl/ehff_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser
// Captures header fields at fixed offsets and builds a frame summary at the
// last byte.
// ----------------------------------------------------------------------------
module ehff_front (
  input  logic                clk,
  input  logic                rst_n,
  input  ehff_pkg::cfg_t      cfg,
  input  logic                byte_take,
  input  logic [7:0]          frame_byte,
  input  logic                end_of_frame,
  output logic                rec_push,
  output ehff_pkg::rec_t      rec
);

  logic [ehff_pkg::POS_W-1:0] pos_r, pos_nxt, len;
  logic [ehff_pkg::MAC_W-1:0] dmac_r, dmac_nxt, smac_r, smac_nxt;
  logic [15:0]                etype_r, etype_nxt;
  logic [7:0]                 proto_r, proto_nxt;
  logic [ehff_pkg::IP_W-1:0]  sip_r, sip_nxt, dip_r, dip_nxt;

  always_comb begin
    dmac_nxt  = dmac_r;
    smac_nxt  = smac_r;
    etype_nxt = etype_r;
    proto_nxt = proto_r;
    sip_nxt   = sip_r;
    dip_nxt   = dip_r;
    if (pos_r < ehff_pkg::POS_SMAC) begin
      dmac_nxt = {dmac_r[ehff_pkg::MAC_W-9:0], frame_byte};
    end else if (pos_r < ehff_pkg::POS_ETYPE) begin
      smac_nxt = {smac_r[ehff_pkg::MAC_W-9:0], frame_byte};
    end else if (pos_r < ehff_pkg::POS_L2END) begin
      etype_nxt = {etype_r[7:0], frame_byte};
    end else if (pos_r == ehff_pkg::POS_PROTO) begin
      proto_nxt = frame_byte;
    end else if (pos_r >= ehff_pkg::POS_SIP && pos_r < ehff_pkg::POS_DIP) begin
      sip_nxt = {sip_r[ehff_pkg::IP_W-9:0], frame_byte};
    end else if (pos_r >= ehff_pkg::POS_DIP && pos_r < ehff_pkg::POS_END) begin
      dip_nxt = {dip_r[ehff_pkg::IP_W-9:0], frame_byte};
    end
    // length including this byte; saturate once the header is covered
    len     = pos_r + 6'd1;
    pos_nxt = (len > ehff_pkg::POS_END) ? ehff_pkg::POS_END : len;
  end

  assign rec_push = byte_take && end_of_frame;

  always_comb begin
    rec.len     = pos_nxt;
    rec.ipv4    = (etype_nxt == ehff_pkg::ETYPE_IPV4);
    rec.arp     = (etype_nxt == ehff_pkg::ETYPE_ARP);
    rec.icmp    = (proto_nxt == ehff_pkg::PROTO_ICMP);
    rec.tcp     = (proto_nxt == ehff_pkg::PROTO_TCP);
    rec.udp     = (proto_nxt == ehff_pkg::PROTO_UDP);
    rec.sip_eq  = (sip_nxt == cfg.ip);
    rec.dip_eq  = (dip_nxt == cfg.ip);
    rec.smac_eq = (smac_nxt == cfg.mac);
    rec.dmac_eq = (dmac_nxt == cfg.mac);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || rec_push) begin
      pos_r   <= '0;
      dmac_r  <= '0;
      smac_r  <= '0;
      etype_r <= '0;
      proto_r <= '0;
      sip_r   <= '0;
      dip_r   <= '0;
    end else if (byte_take) begin
      pos_r   <= pos_nxt;
      dmac_r  <= dmac_nxt;
      smac_r  <= smac_nxt;
      etype_r <= etype_nxt;
      proto_r <= proto_nxt;
      sip_r   <= sip_nxt;
      dip_r   <= dip_nxt;
    end
  end

endmodule

FILE: hdl/ehff_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame summary queue
// Two-entry queue between the parser and the verdict stage.
// ----------------------------------------------------------------------------
module ehff_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ehff_pkg::rec_t wr_rec,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output ehff_pkg::rec_t rd_rec
);

  ehff_pkg::rec_t entry_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign rd_rec    = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

FILE: hdl/ehff_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Verdict stage
// Applies the configured filter to a frame summary and holds the result
// in the output register.
// ----------------------------------------------------------------------------
module ehff_back (
  input  logic           clk,
  input  logic           rst_n,
  input  ehff_pkg::cfg_t cfg,
  input  logic           rec_valid,
  input  ehff_pkg::rec_t rec,
  output logic           rec_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           accept,
  output logic           truncated
);

  logic valid_r, acc_r, trunc_r;
  logic acc_nxt, trunc_nxt;

  assign rec_pop   = rec_valid && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign accept    = acc_r;
  assign truncated = trunc_r;

  always_comb begin
    acc_nxt   = 1'b0;
    trunc_nxt = 1'b0;
    case (cfg.kind)
      ehff_pkg::KIND_IP: begin
        if (rec.len < ehff_pkg::LEN_L2) begin
          trunc_nxt = 1'b1;
        end else if (rec.ipv4) begin
          if (cfg.ftype == ehff_pkg::SEL_SOURCE) begin
            trunc_nxt = (rec.len < ehff_pkg::LEN_SIP);
            acc_nxt   = !trunc_nxt && rec.sip_eq;
          end else begin
            trunc_nxt = (rec.len < ehff_pkg::LEN_DIP);
            acc_nxt   = !trunc_nxt && rec.dip_eq;
          end
        end
      end
      ehff_pkg::KIND_MAC: begin
        if (cfg.ftype == ehff_pkg::SEL_SOURCE) begin
          trunc_nxt = (rec.len < ehff_pkg::LEN_SMAC);
          acc_nxt   = !trunc_nxt && rec.smac_eq;
        end else begin
          trunc_nxt = (rec.len < ehff_pkg::LEN_DMAC);
          acc_nxt   = !trunc_nxt && rec.dmac_eq;
        end
      end
      ehff_pkg::KIND_PROTO: begin
        if (rec.len < ehff_pkg::LEN_L2) begin
          trunc_nxt = 1'b1;
        end else if (rec.arp) begin
          acc_nxt = (cfg.ftype == ehff_pkg::TYPE_ARP);
        end else if (rec.ipv4) begin
          if (rec.len < ehff_pkg::LEN_PROTO) begin
            trunc_nxt = 1'b1;
          end else begin
            acc_nxt = (rec.icmp && cfg.ftype == ehff_pkg::TYPE_ICMP) ||
                      (rec.tcp  && cfg.ftype == ehff_pkg::TYPE_TCP)  ||
                      (rec.udp  && cfg.ftype == ehff_pkg::TYPE_UDP);
          end
        end
      end
      default: begin
        acc_nxt   = 1'b0;
        trunc_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      acc_r   <= acc_nxt;
      trunc_r <= trunc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (rec_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

endmodule

FILE: hdl/ethernet_header_frame_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ethernet header frame filter
// Parses an Ethernet/IPv4 header byte stream and gives one pass/reject
// verdict per frame.
// ----------------------------------------------------------------------------
// Throughput: one frame byte per cycle while in_tready is high; frames may follow back to back.
// Verdict path: the summary is queued at the last byte's transfer, then loaded into
//   the verdict register once that register is free or its verdict is being taken.
// in_tready drops only while the two-entry summary queue is full.
// Reset (rst_n low, synchronous) clears the registers, the parser and the queue.
module ethernet_header_frame_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  logic        in_tlast,   // end_of_frame
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] accept, [1] truncated, [7:2] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ehff_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ehff_pkg::CFG_DAT_W-1:0] cfg_data
);

  ehff_pkg::cfg_t cfg_r;
  ehff_pkg::rec_t push_rec, pop_rec;
  logic           byte_take, rec_push, q_full, q_valid, rec_pop;
  logic           verdict_acc, verdict_trunc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ehff_pkg::REG_KIND: cfg_r.kind  <= cfg_data[1:0];
        ehff_pkg::REG_TYPE: cfg_r.ftype <= cfg_data[2:0];
        ehff_pkg::REG_IP:   cfg_r.ip    <= cfg_data[ehff_pkg::IP_W-1:0];
        ehff_pkg::REG_MAC:  cfg_r.mac   <= cfg_data[ehff_pkg::MAC_W-1:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign byte_take = in_tvalid && in_tready;

  ehff_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .byte_take    (byte_take),
    .frame_byte   (in_tdata),
    .end_of_frame (in_tlast),
    .rec_push     (rec_push),
    .rec          (push_rec)
  );

  ehff_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_push),
    .wr_rec    (push_rec),
    .full      (q_full),
    .pop       (rec_pop),
    .not_empty (q_valid),
    .rd_rec    (pop_rec)
  );

  ehff_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .rec_valid (q_valid),
    .rec       (pop_rec),
    .rec_pop   (rec_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .accept    (verdict_acc),
    .truncated (verdict_trunc)
  );

  assign out_tdata = {6'd0, verdict_trunc, verdict_acc};

endmodule

FILE: hdl/ehff_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame filter port checker
// Watches the top-level ports for handshake and verdict consistency.
// ----------------------------------------------------------------------------
module ehff_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // a stalled verdict holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("verdict changed while stalled");

  // a truncated frame is never passed
  a_trunc_rejects: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("truncated frame accepted");

  // no verdict right after reset
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("verdict valid after reset");

  // queue is empty after reset, so input is open
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind ethernet_header_frame_filter ehff_checker u_ehff_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ethernet header frame filter testbench
// Streams generated Ethernet/IPv4 frames through the filter under a range of
// filter settings and handshake pressure, predicts the verdict of each frame
// from a byte-level header tracker and compares every verdict transfer.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic accept;
    logic truncated;
  } verdict_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [7:0]                     in_tdata;
  logic                           in_tlast;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [7:0]                     out_tdata;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [ehff_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ehff_pkg::CFG_DAT_W-1:0] cfg_data;

  beat_t       pending_beats[$];
  verdict_t    verdicts_due[$];
  beat_t       offered;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        hold_sender = 1'b0;
  logic        rx_hold = 1'b0;

  // mirror of the filter registers
  logic [1:0]                 kind_q = ehff_pkg::KIND_IP;
  logic [2:0]                 type_q = ehff_pkg::SEL_SOURCE;
  logic [ehff_pkg::IP_W-1:0]  ip_q = '0;
  logic [ehff_pkg::MAC_W-1:0] mac_q = '0;

  // header fields captured so far in the current frame
  logic [ehff_pkg::POS_W-1:0] seen_len = '0;
  logic [ehff_pkg::MAC_W-1:0] seen_dmac = '0;
  logic [ehff_pkg::MAC_W-1:0] seen_smac = '0;
  logic [15:0]                seen_etype = '0;
  logic [7:0]                 seen_proto = '0;
  logic [ehff_pkg::IP_W-1:0]  seen_sip = '0;
  logic [ehff_pkg::IP_W-1:0]  seen_dip = '0;

  ethernet_header_frame_filter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] frame_byte
    .in_tlast   (in_tlast),   // end_of_frame
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [0] accept, [1] truncated, [7:2] zero
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [ehff_pkg::MAC_W-1:0] rand_mac();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic verdict_t verdict_for(input logic [ehff_pkg::POS_W-1:0] len);
    verdict_t v;
    v = '0;
    case (kind_q)
      ehff_pkg::KIND_IP: begin
        if (len < ehff_pkg::LEN_L2) v.truncated = 1'b1;
        else if (seen_etype == ehff_pkg::ETYPE_IPV4) begin
          if (type_q == ehff_pkg::SEL_SOURCE) begin
            if (len < ehff_pkg::LEN_SIP) v.truncated = 1'b1;
            else v.accept = (seen_sip == ip_q);
          end else begin
            if (len < ehff_pkg::LEN_DIP) v.truncated = 1'b1;
            else v.accept = (seen_dip == ip_q);
          end
        end
      end
      ehff_pkg::KIND_MAC: begin
        if (type_q == ehff_pkg::SEL_SOURCE) begin
          if (len < ehff_pkg::LEN_SMAC) v.truncated = 1'b1;
          else v.accept = (seen_smac == mac_q);
        end else begin
          if (len < ehff_pkg::LEN_DMAC) v.truncated = 1'b1;
          else v.accept = (seen_dmac == mac_q);
        end
      end
      ehff_pkg::KIND_PROTO: begin
        if (len < ehff_pkg::LEN_L2) v.truncated = 1'b1;
        else if (seen_etype == ehff_pkg::ETYPE_ARP)
          v.accept = (type_q == ehff_pkg::TYPE_ARP);
        else if (seen_etype == ehff_pkg::ETYPE_IPV4) begin
          if (len < ehff_pkg::LEN_PROTO) v.truncated = 1'b1;
          else if (seen_proto == ehff_pkg::PROTO_ICMP)
            v.accept = (type_q == ehff_pkg::TYPE_ICMP);
          else if (seen_proto == ehff_pkg::PROTO_TCP)
            v.accept = (type_q == ehff_pkg::TYPE_TCP);
          else if (seen_proto == ehff_pkg::PROTO_UDP)
            v.accept = (type_q == ehff_pkg::TYPE_UDP);
        end
      end
      default: ;  // unused kind rejects everything
    endcase
    return v;
  endfunction

  task automatic take_frame_byte(input beat_t b);
    logic [ehff_pkg::POS_W-1:0] len;
    if (seen_len < ehff_pkg::POS_SMAC)
      seen_dmac = {seen_dmac[ehff_pkg::MAC_W-9:0], b.data};
    else if (seen_len < ehff_pkg::POS_ETYPE)
      seen_smac = {seen_smac[ehff_pkg::MAC_W-9:0], b.data};
    else if (seen_len < ehff_pkg::POS_L2END) seen_etype = {seen_etype[7:0], b.data};
    else if (seen_len == ehff_pkg::POS_PROTO) seen_proto = b.data;
    else if (seen_len >= ehff_pkg::POS_SIP && seen_len < ehff_pkg::POS_DIP)
      seen_sip = {seen_sip[ehff_pkg::IP_W-9:0], b.data};
    else if (seen_len >= ehff_pkg::POS_DIP && seen_len < ehff_pkg::POS_END)
      seen_dip = {seen_dip[ehff_pkg::IP_W-9:0], b.data};
    len = seen_len + 1'b1;
    seen_len = (len > ehff_pkg::POS_END) ? ehff_pkg::POS_END : len;
    if (b.last) begin
      verdicts_due.push_back(verdict_for(len));
      seen_len = '0;
      seen_dmac = '0;
      seen_smac = '0;
      seen_etype = '0;
      seen_proto = '0;
      seen_sip = '0;
      seen_dip = '0;
    end
  endtask

  // Sender: one transfer per accepted beat, refill from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) take_frame_byte(offered);
      if (!in_tvalid || in_tready) begin
        if (pending_beats.size() != 0 && !hold_sender &&
            $urandom_range(0, 99) >= tx_idle_pct) begin
          offered = pending_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= offered.data;
          in_tlast <= offered.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each verdict transfer against the oldest prediction
  always @(posedge clk) begin : verdict_check
    verdict_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdicts_due.size() == 0) begin
          $error("unexpected verdict transfer, out_tdata %h", out_tdata);
          errors++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_tdata[0] !== want.accept) begin
            $error("accept: expected %0d, got %0d", want.accept, out_tdata[0]);
            errors++;
          end
          if (out_tdata[1] !== want.truncated) begin
            $error("truncated: expected %0d, got %0d", want.truncated, out_tdata[1]);
            errors++;
          end
        end
      end
      out_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic program_reg(input logic [ehff_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ehff_pkg::CFG_DAT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      ehff_pkg::REG_KIND: kind_q = value[1:0];
      ehff_pkg::REG_TYPE: type_q = value[2:0];
      ehff_pkg::REG_IP:   ip_q = value[ehff_pkg::IP_W-1:0];
      ehff_pkg::REG_MAC:  mac_q = value;
      default: ;
    endcase
  endtask

  // Build a frame of n bytes; hit makes the header fields that the filter checks match it
  task automatic queue_frame(input int unsigned n, input bit hit);
    logic [7:0]  f[64];
    logic [15:0] etype;
    logic [7:0]  proto;
    beat_t       b;
    int unsigned pick;
    for (int i = 0; i < 64; i++) f[i] = 8'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 5) etype = ehff_pkg::ETYPE_IPV4;
    else if (pick < 7) etype = ehff_pkg::ETYPE_ARP;
    else if (pick < 8) etype = ehff_pkg::ETYPE_IPV4 ^ (16'h1 << $urandom_range(0, 15));
    else etype = 16'($urandom);
    pick = $urandom_range(0, 4);
    case (pick)
      0: proto = ehff_pkg::PROTO_ICMP;
      1: proto = ehff_pkg::PROTO_TCP;
      2: proto = ehff_pkg::PROTO_UDP;
      default: proto = 8'($urandom);
    endcase
    if (hit) begin
      etype = (kind_q == ehff_pkg::KIND_PROTO && type_q == ehff_pkg::TYPE_ARP) ?
              ehff_pkg::ETYPE_ARP : ehff_pkg::ETYPE_IPV4;
      if (kind_q == ehff_pkg::KIND_PROTO && type_q == ehff_pkg::TYPE_ICMP)
        proto = ehff_pkg::PROTO_ICMP;
      if (kind_q == ehff_pkg::KIND_PROTO && type_q == ehff_pkg::TYPE_TCP)
        proto = ehff_pkg::PROTO_TCP;
      if (kind_q == ehff_pkg::KIND_PROTO && type_q == ehff_pkg::TYPE_UDP)
        proto = ehff_pkg::PROTO_UDP;
    end
    if (hit || $urandom_range(0, 2) == 0)
      for (int i = 0; i < 6; i++) f[i] = mac_q[47-8*i -: 8];
    if (hit || $urandom_range(0, 2) == 0)
      for (int i = 0; i < 6; i++) f[6+i] = mac_q[47-8*i -: 8];
    f[12] = etype[15:8];
    f[13] = etype[7:0];
    f[23] = proto;
    if (hit || $urandom_range(0, 2) == 0)
      for (int i = 0; i < 4; i++) f[26+i] = ip_q[31-8*i -: 8];
    if (hit || $urandom_range(0, 2) == 0)
      for (int i = 0; i < 4; i++) f[30+i] = ip_q[31-8*i -: 8];
    for (int i = 0; i < n; i++) begin
      b.data = f[i];
      b.last = (i == n - 1);
      pending_beats.push_back(b);
    end
  endtask

  function automatic int unsigned pick_len();
    int unsigned edges[17] = '{1, 5, 6, 7, 11, 12, 13, 14, 15, 23, 24, 25, 29, 30,
                               31, 33, 34};
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return edges[$urandom_range(0, 16)];
    if (r < 7) return $urandom_range(1, 34);
    return $urandom_range(35, 64);
  endfunction

  task automatic drain();
    while (pending_beats.size() != 0 || in_tvalid || verdicts_due.size() != 0)
      @(posedge clk);
    // after the last verdict transfer, leave some slack
    repeat (4) @(posedge clk);
  endtask

  // mode 0: plain, 1: long receiver hold, 2: sender pause mid-stream
  task automatic run_settings(input logic [1:0] kind, input logic [2:0] ftype,
                              input logic [ehff_pkg::IP_W-1:0] ip,
                              input logic [ehff_pkg::MAC_W-1:0] mac,
                              input int unsigned tx_pct, input int unsigned rx_pct,
                              input int unsigned mode);
    logic [ehff_pkg::CFG_DAT_W-1:0] junk;
    int unsigned                    queued;
    int unsigned                    n;
    // upper register bits carry noise that must be ignored
    junk = rand_mac();
    program_reg(ehff_pkg::REG_KIND, {junk[ehff_pkg::CFG_DAT_W-1:2], kind});
    junk = rand_mac();
    program_reg(ehff_pkg::REG_TYPE, {junk[ehff_pkg::CFG_DAT_W-1:3], ftype});
    junk = rand_mac();
    program_reg(ehff_pkg::REG_IP,
                {junk[ehff_pkg::CFG_DAT_W-1:ehff_pkg::IP_W], ip});
    program_reg(ehff_pkg::REG_MAC, mac);
    tx_idle_pct <= tx_pct;
    rx_idle_pct <= rx_pct;
    queue_frame(34, 1'b1);
    queued = 34;
    while (queued < 105) begin
      n = pick_len();
      queue_frame(n, $urandom_range(0, 3) == 0);
      queued += n;
    end
    if (mode == 1) begin
      fork
        begin
          @(posedge clk);
          rx_hold <= 1'b1;
          repeat (400) @(posedge clk);
          rx_hold <= 1'b0;
        end
      join_none
    end else if (mode == 2) begin
      while (pending_beats.size() > queued / 2) @(posedge clk);
      hold_sender <= 1'b1;
      @(posedge clk);
      while (in_tvalid || verdicts_due.size() != 0) @(posedge clk);
      repeat (20) @(posedge clk);
      hold_sender <= 1'b0;
    end
    drain();
  endtask

  initial begin
    beat_t b;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: one-byte frame of zeros, then a bare L2 header of ones
    b.data = 8'h00;
    b.last = 1'b1;
    pending_beats.push_back(b);
    for (int i = 0; i < 14; i++) begin
      b.data = 8'hFF;
      b.last = (i == 13);
      pending_beats.push_back(b);
    end
    queue_frame(34, 1'b1);
    queue_frame(64, 1'b0);
    drain();

    run_settings(ehff_pkg::KIND_IP, ehff_pkg::SEL_SOURCE, '0, '0, 0, 0, 0);
    run_settings(ehff_pkg::KIND_IP, 3'd1, '1, rand_mac(), 47, 0, 0);
    run_settings(ehff_pkg::KIND_IP, 3'd7, $urandom, rand_mac(), 0, 47, 0);
    run_settings(ehff_pkg::KIND_MAC, ehff_pkg::SEL_SOURCE, $urandom, '1, 20, 20, 1);
    run_settings(ehff_pkg::KIND_MAC, 3'd1, '0, '0, 0, 0, 0);
    run_settings(ehff_pkg::KIND_MAC, ehff_pkg::TYPE_UDP, $urandom, rand_mac(), 47, 0, 2);
    run_settings(ehff_pkg::KIND_PROTO, ehff_pkg::TYPE_ARP, $urandom, rand_mac(), 0, 47, 0);
    run_settings(ehff_pkg::KIND_PROTO, ehff_pkg::TYPE_ICMP, $urandom, rand_mac(),
                 20, 20, 0);
    run_settings(ehff_pkg::KIND_PROTO, ehff_pkg::TYPE_TCP, $urandom, rand_mac(), 0, 0, 1);
    run_settings(ehff_pkg::KIND_PROTO, ehff_pkg::TYPE_UDP, $urandom, rand_mac(), 47, 0, 0);
    run_settings(ehff_pkg::KIND_PROTO, ehff_pkg::SEL_SOURCE, $urandom, rand_mac(),
                 0, 47, 0);
    run_settings(ehff_pkg::KIND_PROTO, 3'd7, $urandom, rand_mac(), 20, 20, 0);
    run_settings(2'd3, ehff_pkg::TYPE_TCP, $urandom, rand_mac(), 0, 0, 0);
    run_settings(ehff_pkg::KIND_IP, ehff_pkg::SEL_SOURCE, $urandom, rand_mac(), 20, 20, 2);

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
